/* hw/rtl/i2cmb_pkg.sv */
// Package for the I2C master bit engine: command codes, queue item type, phase limits.
package i2cmb_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned BYTE_BITS   = 8;
  localparam int unsigned PHASE_W     = 5;

  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4,
    CMD_ACK   = 3'd5,
    CMD_NACK  = 3'd6,
    CMD_WAIT  = 3'd7
  } cmd_e;

  typedef struct packed {
    cmd_e                   cmd;
    logic                   is_cmd;
    logic [BYTE_BITS-1:0]   wdata;
    logic                   sda;
  } item_t;

  // last phase index of each command
  function automatic logic [PHASE_W-1:0] cmd_last(input cmd_e cmd);
    logic [PHASE_W-1:0] last;
    case (cmd)
      CMD_START: last = PHASE_W'(1);
      CMD_STOP:  last = PHASE_W'(1);
      CMD_WRITE: last = PHASE_W'(4 * BYTE_BITS - 1);
      CMD_READ:  last = PHASE_W'(3 * BYTE_BITS - 1);
      CMD_ACK:   last = PHASE_W'(3);
      CMD_NACK:  last = PHASE_W'(2);
      CMD_WAIT:  last = PHASE_W'(2);
      default:   last = PHASE_W'(0);
    endcase
    return last;
  endfunction

endpackage

/* hw/rtl/i2cmb_front.sv */
// Front end: accepts input items, classifies the kind and queues them for the sequencer.
module i2cmb_front #(
  parameter int unsigned Depth = i2cmb_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          in_kind_i,
  input  logic [7:0]          in_wdata_i,
  input  logic                in_sda_i,
  output logic                q_valid_o,
  input  logic                q_pop_i,
  output i2cmb_pkg::item_t    q_item_o
);
  import i2cmb_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t               mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                push, pop;
  item_t               item_in;

  always_comb begin
    item_in.cmd    = cmd_e'(in_kind_i);
    item_in.is_cmd = (cmd_e'(in_kind_i) != CMD_IDLE);
    item_in.wdata  = in_wdata_i;
    item_in.sda    = in_sda_i;
  end

  assign in_ready_o = (count_q != CntW'(Depth));
  assign q_valid_o  = (count_q != '0);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count exceeds depth");
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("queue count did not follow push");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> !pop)
    else $error("pop from empty queue");
`endif

endmodule

/* hw/rtl/i2cmb_seq.sv */
// Back end: bit-level line sequencer with a registered result stage.
module i2cmb_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  output logic                q_pop_o,
  input  i2cmb_pkg::item_t    q_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                out_scl_o,
  output logic                out_sda_o,
  output logic                out_busy_o,
  output logic                out_done_o,
  output logic [7:0]          out_rdata_o,
  output logic                out_ack_missing_o
);
  import i2cmb_pkg::*;

  cmd_e                 active_q, active_d, cmd;
  logic [PHASE_W-1:0]   phase_q, phase_d, p;
  logic [1:0]           sub_q, sub_d, sub_cur;
  logic [7:0]           shift_q, shift_d, shift_cur;
  logic [7:0]           rbyte_q, rbyte_d, rbyte_cur;
  logic                 scl_q, scl_d, sda_q, sda_d, ack_q, ack_d;
  logic                 start, done, step, wbit;

  logic                 ovalid_q;
  logic                 oscl_q, osda_q, obusy_q, odone_q, oack_q;
  logic [7:0]           ordata_q;

  assign step    = q_valid_i && (!ovalid_q || out_ready_i);
  assign q_pop_o = step;

  assign start     = (active_q == CMD_IDLE) && q_item_i.is_cmd;
  assign cmd       = start ? q_item_i.cmd : active_q;
  assign p         = start ? '0 : phase_q;
  assign sub_cur   = start ? '0 : sub_q;
  assign shift_cur = (start && q_item_i.cmd == CMD_WRITE) ? q_item_i.wdata : shift_q;
  assign rbyte_cur = (start && q_item_i.cmd == CMD_READ) ? '0 : rbyte_q;
  assign wbit      = shift_cur[7];

  always_comb begin
    scl_d   = scl_q;
    sda_d   = sda_q;
    ack_d   = ack_q;
    shift_d = shift_cur;
    rbyte_d = rbyte_cur;
    sub_d   = '0;
    case (cmd)
      CMD_START: begin
        scl_d = 1'b1;
        sda_d = (p != '0) ? 1'b0 : 1'b1;
      end
      CMD_STOP: begin
        scl_d = 1'b1;
        sda_d = (p != '0);
      end
      CMD_ACK: begin
        scl_d = (p == PHASE_W'(2));
        sda_d = !((p == PHASE_W'(1)) || (p == PHASE_W'(2)));
      end
      CMD_NACK: begin
        scl_d = (p == PHASE_W'(1));
        sda_d = 1'b1;
      end
      CMD_WAIT: begin
        scl_d = (p == PHASE_W'(1));
        sda_d = 1'b1;
        if (p == PHASE_W'(1)) begin
          ack_d = q_item_i.sda;
        end
      end
      CMD_WRITE: begin
        case (p[1:0])
          2'd0: begin
            scl_d = 1'b0;
            sda_d = 1'b0;
          end
          2'd1: begin
            scl_d = 1'b0;
            sda_d = wbit;
          end
          2'd2: begin
            scl_d = 1'b1;
            sda_d = wbit;
          end
          default: begin
            scl_d   = 1'b0;
            sda_d   = wbit;
            shift_d = {shift_cur[6:0], 1'b0};
          end
        endcase
      end
      CMD_READ: begin
        scl_d = (sub_cur == 2'd1);
        if (sub_cur == 2'd1) begin
          rbyte_d = {rbyte_cur[6:0], q_item_i.sda};
        end
        sub_d = (sub_cur == 2'd2) ? 2'd0 : sub_cur + 2'd1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    done     = 1'b0;
    active_d = cmd;
    phase_d  = p;
    if (cmd != CMD_IDLE) begin
      if (p == cmd_last(cmd)) begin
        done     = 1'b1;
        active_d = CMD_IDLE;
        phase_d  = '0;
      end else begin
        phase_d = p + PHASE_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= CMD_IDLE;
      phase_q  <= '0;
      sub_q    <= '0;
      shift_q  <= '0;
      rbyte_q  <= '0;
      scl_q    <= 1'b1;
      sda_q    <= 1'b1;
      ack_q    <= 1'b0;
    end else if (step) begin
      active_q <= active_d;
      phase_q  <= phase_d;
      sub_q    <= done ? 2'd0 : sub_d;
      shift_q  <= shift_d;
      rbyte_q  <= rbyte_d;
      scl_q    <= scl_d;
      sda_q    <= sda_d;
      ack_q    <= ack_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (step) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      oscl_q   <= scl_d;
      osda_q   <= sda_d;
      obusy_q  <= (active_d != CMD_IDLE);
      odone_q  <= done;
      ordata_q <= rbyte_d;
      oack_q   <= ack_d;
    end
  end

  assign out_valid_o       = ovalid_q;
  assign out_scl_o         = oscl_q;
  assign out_sda_o         = osda_q;
  assign out_busy_o        = obusy_q;
  assign out_done_o        = odone_q;
  assign out_rdata_o       = ordata_q;
  assign out_ack_missing_o = oack_q;

`ifndef SYNTHESIS
  a_idle_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q == CMD_IDLE) |-> (phase_q == '0 && sub_q == '0))
    else $error("phase counter not cleared while idle");
  a_phase_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q != CMD_IDLE) |-> (phase_q <= cmd_last(active_q)))
    else $error("phase counter beyond command length");
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && odone_q) |-> !obusy_q)
    else $error("done reported while still busy");
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !out_ready_i) |=> (ovalid_q && $stable(ordata_q) && $stable(odone_q)))
    else $error("result changed while stalled");
`endif

endmodule

/* hw/rtl/i2c_master_bit_engine_top.sv */
// Top level of the I2C master bit engine: input queue in front of the line sequencer.
// A result is presented once its item has passed the queue and then the result register.
// Throughput: one item per cycle; the sequencer takes one queued item each cycle the result
// register is free or being drained, and the four-entry queue absorbs output stalls.
// Reset (rst_ni, asynchronous, active low): idle, SCL and SDA released high, read byte and
// acknowledge flag cleared, queue and result register empty; no clearing pass.
module i2c_master_bit_engine_top #(
  parameter int unsigned QueueDepth = i2cmb_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [7:0] write_data, [8] sda_in, [15:9] zero
  input  logic [2:0]  s_axis_tuser_i,   // [2:0] kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [0] scl_out, [1] sda_out, [2] busy_res,
                                        // [10:3] read_data, [11] ack_missing, [15:12] zero
  output logic        m_axis_tlast_o    // done_res
);
  import i2cmb_pkg::*;

  logic       q_valid, q_pop;
  item_t      q_item;
  logic       scl, sda, busy, done, ack_missing;
  logic [7:0] rdata;

  i2cmb_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_kind_i  (s_axis_tuser_i),
    .in_wdata_i (s_axis_tdata_i[7:0]),
    .in_sda_i   (s_axis_tdata_i[8]),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_item_o   (q_item)
  );

  i2cmb_seq u_seq (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .q_pop_o           (q_pop),
    .q_item_i          (q_item),
    .out_valid_o       (m_axis_tvalid_o),
    .out_ready_i       (m_axis_tready_i),
    .out_scl_o         (scl),
    .out_sda_o         (sda),
    .out_busy_o        (busy),
    .out_done_o        (done),
    .out_rdata_o       (rdata),
    .out_ack_missing_o (ack_missing)
  );

  assign m_axis_tdata_o = {4'b0000, ack_missing, rdata, busy, sda, scl};
  assign m_axis_tlast_o = done;

endmodule
